[rtl/window_alarm_latch_8ch_assert.svh]
// ----------------------------------------------------------------------------
// window alarm latch assertion macros
// concurrent checks on clk with rst_n as disable; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef WINDOW_ALARM_LATCH_8CH_ASSERT_SVH
`define WINDOW_ALARM_LATCH_8CH_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every edge
`define WAL8_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define WAL8_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WAL8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WAL8_ASSERT_ALWAYS(label, prop, msg)
`define WAL8_ASSERT_IMPLY(label, ante, cons, msg)
`define WAL8_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/wal8_pkg.sv]
// ----------------------------------------------------------------------------
// wal8_pkg
// shared types and codes of the eight-channel window alarm
// ----------------------------------------------------------------------------
package wal8_pkg;

    localparam int NUM_CH = 8;

    // request operation codes
    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_CLEAR = 2'd1,
        OP_RESET = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // per-channel mode codes
    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_LIVE  = 2'd1,
        MODE_LATCH = 2'd2,
        MODE_HOLD  = 2'd3
    } mode_t;

    // led pair codes
    localparam logic [1:0] LED_OFF   = 2'b00;
    localparam logic [1:0] LED_ALARM = 2'b01;
    localparam logic [1:0] LED_CLEAR = 2'b10;

    // configuration register indexes
    localparam logic [2:0] CFG_MODES  = 3'd0;
    localparam logic [2:0] CFG_HIGH_A = 3'd1;
    localparam logic [2:0] CFG_HIGH_B = 3'd2;
    localparam logic [2:0] CFG_LOW_A  = 3'd3;
    localparam logic [2:0] CFG_LOW_B  = 3'd4;

    typedef struct packed {
        op_t                operation;
        logic [3:0]         channel;
        logic signed [15:0] sample_0;
        logic signed [15:0] sample_1;
        logic signed [15:0] sample_2;
        logic signed [15:0] sample_3;
        logic signed [15:0] sample_4;
        logic signed [15:0] sample_5;
        logic signed [15:0] sample_6;
        logic signed [15:0] sample_7;
    } in_t;

    typedef struct packed {
        logic [15:0] led_word;
        logic [7:0]  alarm_flags;
        logic        shift_out;
    } out_t;

    // state of one channel
    typedef struct packed {
        logic       latch;
        logic       status;
        logic [1:0] pair;
    } lane_state_t;

endpackage

[rtl/wal8_lane.sv]
// ----------------------------------------------------------------------------
// wal8_lane
// one channel: window compare and next latch, status and led pair
// ----------------------------------------------------------------------------
module wal8_lane (
    input  wal8_pkg::op_t         op,
    input  logic                  hit,
    input  wal8_pkg::mode_t       mode,
    input  logic signed [15:0]    sample,
    input  logic signed [15:0]    hi_limit,
    input  logic signed [15:0]    lo_limit,
    input  wal8_pkg::lane_state_t cur,
    output wal8_pkg::lane_state_t nxt,
    output logic                  cleared
);
    import wal8_pkg::*;

    logic outside;
    logic latched;

    always_comb
    begin
        outside = (sample > hi_limit) || (sample < lo_limit);
        latched = cur.latch | outside;
        nxt     = cur;
        cleared = 1'b0;
        unique case (op)
            OP_CHECK:
            begin
                unique case (mode)
                    MODE_OFF:
                    begin
                        nxt.status = 1'b0;
                        nxt.pair   = LED_OFF;
                    end
                    MODE_LIVE:
                    begin
                        nxt.status = outside;
                        nxt.pair   = outside ? LED_ALARM : LED_CLEAR;
                    end
                    MODE_LATCH:
                    begin
                        nxt.latch  = latched;
                        nxt.status = latched;
                        nxt.pair   = latched ? LED_ALARM : LED_CLEAR;
                    end
                    MODE_HOLD:
                    begin
                        nxt = cur;
                    end
                endcase
            end
            OP_CLEAR:
            begin
                if (hit && cur.latch)
                begin
                    nxt.latch  = 1'b0;
                    nxt.status = 1'b0;
                    nxt.pair   = LED_CLEAR;
                    cleared    = 1'b1;
                end
            end
            OP_RESET:
            begin
                nxt.latch = 1'b0;
                nxt.pair  = LED_OFF;
            end
            OP_NONE:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

[rtl/wal8_merge.sv]
// ----------------------------------------------------------------------------
// wal8_merge
// gathers the lanes into the led word, flags and send decision
// ----------------------------------------------------------------------------
module wal8_merge (
    input  wal8_pkg::op_t         op,
    input  wal8_pkg::lane_state_t lane_nxt [wal8_pkg::NUM_CH],
    input  logic [7:0]            lane_cleared,
    input  logic [15:0]           last_sent,
    output logic [7:0]            latch_next,
    output logic [15:0]           last_next,
    output wal8_pkg::out_t        result
);
    import wal8_pkg::*;

    logic send_ok;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            result.led_word[2*i +: 2] = lane_nxt[i].pair;
            result.alarm_flags[i]     = lane_nxt[i].status;
            latch_next[i]             = lane_nxt[i].latch;
        end
        // a check always compares; a clear only when a latch actually dropped
        send_ok = (op == OP_CHECK) || ((op == OP_CLEAR) && (|lane_cleared));
        result.shift_out = send_ok && (result.led_word != last_sent);
        if (op == OP_RESET)
            last_next = '0;
        else if (result.shift_out)
            last_next = result.led_word;
        else
            last_next = last_sent;
    end

endmodule

[rtl/window_alarm_latch_8ch.sv]
// ----------------------------------------------------------------------------
// window_alarm_latch_8ch
// eight-channel window comparator with live and latching alarms and led pairs
// ----------------------------------------------------------------------------
//  channel   signals                        direction   moves
//  in        in_valid in_ready in_data      sink        one request per accept
//  out       out_valid out_ready out_data   source      one result per request
//  cfg       cfg_wen cfg_index cfg_wdata    sink        register write, no wait
//
//  one request per cycle while in_ready is high; its result is registered
//  the eight lane compares and the merge are combinational before the state regs
//  a two-entry output buffer keeps in_ready high while one result waits
//  in_ready drops only when both output entries are full
//  reset clears the configuration, latches, led words and alarm flags
// ----------------------------------------------------------------------------
`include "window_alarm_latch_8ch_assert.svh"

module window_alarm_latch_8ch (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  wal8_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output wal8_pkg::out_t  out_data,
    input  logic            cfg_wen,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_wdata
);
    import wal8_pkg::*;

    // configuration registers
    logic [15:0] modes_reg;
    logic [63:0] high_a_reg;
    logic [63:0] high_b_reg;
    logic [63:0] low_a_reg;
    logic [63:0] low_b_reg;

    // channel state
    logic [7:0]  latch_reg;
    logic [7:0]  alarm_reg;
    logic [15:0] led_cur_reg;
    logic [15:0] led_last_reg;

    // output buffer: main entry drives the port, skid catches a stalled request
    out_t        out_reg;
    out_t        out_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_t        skid_reg;
    out_t        skid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;

    logic        in_fire;
    logic        out_fire;

    logic signed [15:0] samp [NUM_CH];
    lane_state_t lane_cur [NUM_CH];
    lane_state_t lane_nxt [NUM_CH];
    logic [7:0]  lane_cleared;

    logic [7:0]  latch_next;
    logic [15:0] last_next;
    out_t        result;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // configuration writes; indexes past the list fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg  <= '0;
            high_a_reg <= '0;
            high_b_reg <= '0;
            low_a_reg  <= '0;
            low_b_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_MODES:  modes_reg  <= cfg_wdata[15:0];
                CFG_HIGH_A: high_a_reg <= cfg_wdata;
                CFG_HIGH_B: high_b_reg <= cfg_wdata;
                CFG_LOW_A:  low_a_reg  <= cfg_wdata;
                CFG_LOW_B:  low_b_reg  <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // unpack the samples so each lane taps its own
    always_comb
    begin
        samp[0] = in_data.sample_0;
        samp[1] = in_data.sample_1;
        samp[2] = in_data.sample_2;
        samp[3] = in_data.sample_3;
        samp[4] = in_data.sample_4;
        samp[5] = in_data.sample_5;
        samp[6] = in_data.sample_6;
        samp[7] = in_data.sample_7;
    end

    // one lane per channel; channels 1 to 4 take their limits from the a words
    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_lane
        localparam int SLOT = g % 4;

        logic signed [15:0] hi_lim;
        logic signed [15:0] lo_lim;

        assign hi_lim = (g < 4) ? high_a_reg[16*SLOT +: 16] : high_b_reg[16*SLOT +: 16];
        assign lo_lim = (g < 4) ? low_a_reg[16*SLOT +: 16]  : low_b_reg[16*SLOT +: 16];

        assign lane_cur[g].latch  = latch_reg[g];
        assign lane_cur[g].status = alarm_reg[g];
        assign lane_cur[g].pair   = led_cur_reg[2*g +: 2];

        wal8_lane u_lane (
            .op       (in_data.operation),
            .hit      (in_data.channel == 4'(g + 1)),
            .mode     (mode_t'(modes_reg[2*g +: 2])),
            .sample   (samp[g]),
            .hi_limit (hi_lim),
            .lo_limit (lo_lim),
            .cur      (lane_cur[g]),
            .nxt      (lane_nxt[g]),
            .cleared  (lane_cleared[g])
        );
    end

    wal8_merge u_merge (
        .op           (in_data.operation),
        .lane_nxt     (lane_nxt),
        .lane_cleared (lane_cleared),
        .last_sent    (led_last_reg),
        .latch_next   (latch_next),
        .last_next    (last_next),
        .result       (result)
    );

    // state moves on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg    <= '0;
            alarm_reg    <= '0;
            led_cur_reg  <= '0;
            led_last_reg <= '0;
        end
        else if (in_fire)
        begin
            latch_reg    <= latch_next;
            alarm_reg    <= result.alarm_flags;
            led_cur_reg  <= result.led_word;
            led_last_reg <= last_next;
        end
    end

    // output buffer steering
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                // no request is taken while the skid is full
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // skid only fills behind a waiting main entry
    `WAL8_ASSERT_IMPLY(a_skid_behind_main, skid_valid_reg, out_valid_reg, "skid full with empty main")
    // every step either sends the word or leaves it unchanged from the last send
    `WAL8_ASSERT_ALWAYS(a_led_synced, led_cur_reg == led_last_reg, "led word out of sync")
    // reset-all drops every latch
    `WAL8_ASSERT_NEXT(a_reset_clears, in_fire && (in_data.operation == OP_RESET), latch_reg == 8'd0, "latch survived reset-all")
    // a request that meets a stalled full main entry lands in the skid
    `WAL8_ASSERT_NEXT(a_stall_to_skid, in_fire && out_valid_reg && !out_ready, skid_valid_reg, "stalled request lost")

endmodule
